### hdl/alifd_pkg.sv
// ----------------------------------------------------------------------------
// alifd_pkg
// shared types and codes for the insert/find/delete list unit
// ----------------------------------------------------------------------------
package alifd_pkg;

    // op codes, code 3 is unused and acts as a no-op
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    // field widths
    localparam int unsigned OP_W    = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned COUNT_W = 5;

    // per-cell load control
    typedef struct packed {
        logic take_prev;
        logic take_next;
    } t_cell_ctrl;

endpackage

### hdl/alifd_cell.sv
// ----------------------------------------------------------------------------
// alifd_cell
// one list slot: byte plus valid bit, loads from either neighbour
// ----------------------------------------------------------------------------
module alifd_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  alifd_pkg::t_cell_ctrl          i_ctrl,
    input  logic [alifd_pkg::BYTE_W-1:0]   i_key,
    input  logic [alifd_pkg::BYTE_W-1:0]   i_prev_data,
    input  logic                           i_prev_valid,
    input  logic [alifd_pkg::BYTE_W-1:0]   i_next_data,
    input  logic                           i_next_valid,
    output logic [alifd_pkg::BYTE_W-1:0]   o_data,
    output logic                           o_valid,
    output logic                           o_match
);
    import alifd_pkg::*;

    logic [BYTE_W-1:0] r_data;
    logic [BYTE_W-1:0] n_data;
    logic              r_valid;
    logic              n_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.take_prev) begin
            n_data  = i_prev_data;
            n_valid = i_prev_valid;
        end else if (i_ctrl.take_next) begin
            n_data  = i_next_data;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_match = r_valid && (r_data == i_key);

endmodule

### hdl/array_list_insert_find_delete_unit.sv
// ----------------------------------------------------------------------------
// array_list_insert_find_delete_unit
// bounded ordered byte list with insert-at-front, find and delete
// ----------------------------------------------------------------------------
// The unit takes one item per clock and returns its result in the output
// register on the following cycle; a stalled result holds the input side off
// only while it is still waiting. The list is a row of CAPACITY cells, each
// holding one byte and a valid bit: every cell compares its byte against the
// item's value in the same cycle, the first hit is picked by a priority mask,
// and on the same edge the row shifts one place toward the end (insert) or
// closes the gap from the hit onward (delete). That compare and shift across the
// whole row at once is what sets the rate of one item per cycle. Reset only
// clears the valid bits and the count, so no clearing pass is needed and the
// unit takes items from the first cycle after reset.
// ----------------------------------------------------------------------------
module array_list_insert_find_delete_unit #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [alifd_pkg::OP_W-1:0]      i_op,
    input  logic [alifd_pkg::BYTE_W-1:0]    i_value,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [alifd_pkg::POS_W-1:0]     o_position,
    output logic                            o_hit,
    output logic [alifd_pkg::STAT_W-1:0]    o_status,
    output logic [alifd_pkg::COUNT_W-1:0]   o_entries
);
    import alifd_pkg::*;

    localparam int unsigned IDX_W  = $clog2(CAPACITY);
    localparam int unsigned FILL_W = $clog2(CAPACITY + 1);

    // handshake
    logic w_accept;
    logic r_out_valid;
    logic n_out_valid;

    // cell row wiring
    t_cell_ctrl        w_ctrl  [CAPACITY];
    logic [BYTE_W-1:0] w_data  [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_first;
    logic [CAPACITY-1:0] w_from_first;

    // decode
    logic w_is_ins;
    logic w_is_find;
    logic w_is_del;
    logic w_full;
    logic w_found;
    logic w_do_ins;
    logic w_do_del;
    logic [IDX_W-1:0] w_idx;

    // count and result registers
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    logic [POS_W-1:0]   r_position;
    logic [POS_W-1:0]   n_position;
    logic               r_hit;
    logic               n_hit;
    logic [STAT_W-1:0]  r_status;
    logic [STAT_W-1:0]  n_status;
    logic [COUNT_W-1:0] r_entries;
    logic [31:0]        w_idx_ext;
    logic [31:0]        w_fill_ext;

    // a waiting result blocks the input only while it is itself stalled
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_is_ins  = (i_op == OP_INSERT);
    assign w_is_find = (i_op == OP_FIND);
    assign w_is_del  = (i_op == OP_DELETE);

    // list is full when the last cell holds an entry
    assign w_full  = w_valid[CAPACITY-1];
    assign w_found = |w_match;

    // lowest matching cell, and every cell from it to the end of the row
    assign w_first      = w_match & (~w_match + CAPACITY'(1));
    assign w_from_first = ~(w_first - CAPACITY'(1));

    assign w_do_ins = w_accept && w_is_ins && !w_full;
    assign w_do_del = w_accept && w_is_del && w_found;

    // one-hot to index
    always_comb begin
        w_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                w_idx = w_idx | IDX_W'(i);
            end
        end
    end

    // cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [BYTE_W-1:0] w_prev_data;
        logic              w_prev_valid;
        logic [BYTE_W-1:0] w_next_data;
        logic              w_next_valid;

        if (g == 0) begin : g_head
            // new entry enters at the head
            assign w_prev_data  = i_value;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_data  = w_data[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            // tail empties on a delete
            assign w_next_data  = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_mid
            assign w_next_data  = w_data[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        assign w_ctrl[g].take_prev = w_do_ins;
        assign w_ctrl[g].take_next = w_do_del && w_from_first[g];

        alifd_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl[g]),
            .i_key        (i_value),
            .i_prev_data  (w_prev_data),
            .i_prev_valid (w_prev_valid),
            .i_next_data  (w_next_data),
            .i_next_valid (w_next_valid),
            .o_data       (w_data[g]),
            .o_valid      (w_valid[g]),
            .o_match      (w_match[g])
        );
    end

    // position and count are cut to their field widths
    assign w_idx_ext  = 32'(w_idx);
    assign w_fill_ext = 32'(n_fill);

    // next count, result fields and output valid
    always_comb begin
        n_fill      = r_fill;
        n_position  = r_position;
        n_hit       = r_hit;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        if (w_do_ins) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (w_do_del) begin
            n_fill = r_fill - FILL_W'(1);
        end
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_position  = '0;
            n_hit       = 1'b0;
            n_status    = ST_DONE;
            if (w_is_ins) begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_hit = 1'b1;
                end
            end else if (w_is_find || w_is_del) begin
                if (w_found) begin
                    n_hit      = 1'b1;
                    n_position = w_idx_ext[POS_W-1:0];
                end else begin
                    n_status = ST_MISS;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        r_position <= n_position;
        r_hit      <= n_hit;
        r_status   <= n_status;
        if (w_accept) begin
            r_entries <= w_fill_ext[COUNT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_position;
    assign o_hit       = r_hit;
    assign o_status    = r_status;
    assign o_entries   = r_entries;

`ifndef SYNTH
    // count never runs past the row
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(CAPACITY))
        else $error("entry count above capacity");

    // valid bits in the row agree with the count
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_fill))
        else $error("cell valid bits disagree with entry count");

    // an insert into a list with room is reported as accepted
    a_ins_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_ins |=> (o_out_valid && o_hit && (o_status == ST_DONE)))
        else $error("accepted insert not reported as a hit");

    // a hit never carries a failure status
    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (o_status == ST_DONE))
        else $error("hit reported with a failure status");

    // a successful delete shrinks the list by one
    a_del_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_del |=> (r_fill == $past(r_fill) - FILL_W'(1)))
        else $error("delete did not reduce entry count");
`endif

endmodule

### dv/tb_array_list_insert_find_delete_unit.sv
// ----------------------------------------------------------------------------
// tb_array_list_insert_find_delete_unit
// self-checking bench for the insert/find/delete byte list
// ----------------------------------------------------------------------------
// A short directed run takes the list from empty to full and exercises the
// refused insert, finds and deletes at the front, the back and on a duplicate,
// misses and the unused op code. It is followed by random traffic in four
// idling phases. The random traffic moves in tides of insert-heavy and
// delete-heavy stretches over a small pool of byte values, so the list keeps
// swinging between empty and full and most finds and deletes hit. Every
// accepted item goes through a local list model and every result is checked
// field by field against it.
// ----------------------------------------------------------------------------
module tb_array_list_insert_find_delete_unit;

    import alifd_pkg::*;

    localparam int unsigned LIST_DEPTH  = 16;
    localparam logic [1:0]  OP_NOP      = 2'd3;    // unused code, no-op
    localparam int unsigned PHASE_ITEMS = 370;
    localparam int unsigned HOLD_AT     = 100;     // accepted items before the long stall
    localparam int unsigned HOLD_LEN    = 250;
    localparam int unsigned DRAIN_WAIT  = 10;
    localparam longint      RUN_LIMIT   = 64'd4_000_000;

    // one item on the input channel
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] value;
    } t_list_cmd;

    // one result as the unit should report it
    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic               hit;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] entries;
    } t_list_result;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_op       = '0;
    logic [BYTE_W-1:0]    i_value    = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [POS_W-1:0]     o_position;
    logic                 o_hit;
    logic [STAT_W-1:0]    o_status;
    logic [COUNT_W-1:0]   o_entries;

    array_list_insert_find_delete_unit #(
        .CAPACITY (LIST_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_position  (o_position),
        .o_hit       (o_hit),
        .o_status    (o_status),
        .o_entries   (o_entries)
    );

    // ------------------------------------------------------------------
    // shadow list: entries 0..list_fill-1 are live, nothing beyond is read
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] list_slots [LIST_DEPTH];
    int unsigned       list_fill = 0;

    t_list_cmd    pending_items [$];     // items still to be offered
    t_list_result expected_results [$];  // results owed by the unit, oldest first

    // phase knobs, percent of cycles spent idle or stalling
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // bookkeeping
    int unsigned n_accepted  = 0;
    int unsigned n_results   = 0;
    int unsigned n_errors    = 0;
    int unsigned n_inserts   = 0;
    int unsigned n_finds     = 0;
    int unsigned n_deletes   = 0;
    int unsigned n_nops      = 0;
    int unsigned n_refused   = 0;
    int unsigned n_misses    = 0;
    int unsigned peak_fill   = 0;
    int unsigned hold_left   = 0;
    logic        hold_done   = 1'b0;

    t_list_cmd    next_cmd;
    t_list_result predicted;
    t_list_result owed;

    // apply one item to the shadow list and return the result it should give
    function automatic t_list_result list_apply(logic [OP_W-1:0] op, logic [BYTE_W-1:0] value);
        t_list_result r;
        int unsigned  i;
        int unsigned  at;
        r = '0;
        r.status = ST_DONE;
        case (op)
            OP_INSERT: begin
                if (list_fill < LIST_DEPTH) begin
                    for (i = list_fill; i > 0; i--)
                        list_slots[i] = list_slots[i-1];
                    list_slots[0] = value;
                    list_fill++;
                    r.hit = 1'b1;
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_FIND, OP_DELETE: begin
                // first match wins, at == list_fill means no match
                at = list_fill;
                for (i = 0; i < list_fill; i++) begin
                    if (at == list_fill && list_slots[i] == value)
                        at = i;
                end
                if (at < list_fill) begin
                    r.position = at[POS_W-1:0];
                    r.hit = 1'b1;
                    if (op == OP_DELETE) begin
                        // close the gap behind the removed entry
                        for (i = at; i + 1 < list_fill; i++)
                            list_slots[i] = list_slots[i+1];
                        list_fill--;
                    end
                end else begin
                    r.status = ST_MISS;
                end
            end
            default: begin
                // unused code leaves the list alone
            end
        endcase
        r.entries = list_fill[COUNT_W-1:0];
        return r;
    endfunction

    task automatic push_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] value);
        t_list_cmd c;
        c.op = op;
        c.value = value;
        pending_items.push_back(c);
    endtask

    // random traffic in tides: each tide has its own insert bias and its own
    // small pool of values, so the list fills, empties and mostly hits
    task automatic queue_random_items(input int unsigned count);
        int unsigned       k;
        int unsigned       tide_left;
        int unsigned       insert_pct;
        logic [BYTE_W-1:0] pool [5];
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] value;
        tide_left = 0;
        insert_pct = 50;
        for (k = 0; k < count; k++) begin
            if (tide_left == 0) begin
                tide_left = $urandom_range(60, 8);
                insert_pct = $urandom_range(90, 10);
                foreach (pool[p])
                    pool[p] = BYTE_W'($urandom_range(255));
            end
            tide_left--;
            if ($urandom_range(99) < 3)
                op = OP_NOP;
            else if ($urandom_range(99) < insert_pct)
                op = OP_INSERT;
            else if ($urandom_range(1) == 0)
                op = OP_FIND;
            else
                op = OP_DELETE;
            // mostly pool values so finds and deletes land, some free noise
            if ($urandom_range(99) < 85)
                value = pool[$urandom_range(4)];
            else
                value = BYTE_W'($urandom_range(255));
            push_item(op, value);
        end
    endtask

    // directed opening: empty-list corner cases, fill to capacity, refused
    // insert, hits at both ends and on a duplicate, removals front/middle/back
    task automatic queue_directed_items();
        push_item(OP_FIND,   8'h00);   // miss on an empty list
        push_item(OP_DELETE, 8'hFF);   // delete miss on an empty list
        push_item(OP_NOP,    8'h3C);   // unused code with nothing held
        push_item(OP_INSERT, 8'h00);
        push_item(OP_INSERT, 8'hFF);
        push_item(OP_INSERT, 8'h5A);
        push_item(OP_INSERT, 8'hA5);
        push_item(OP_INSERT, 8'h5A);   // duplicate value
        push_item(OP_INSERT, 8'h01);
        push_item(OP_INSERT, 8'h80);
        push_item(OP_INSERT, 8'h7F);
        push_item(OP_INSERT, 8'h10);
        push_item(OP_INSERT, 8'h20);
        push_item(OP_INSERT, 8'h30);
        push_item(OP_INSERT, 8'h40);
        push_item(OP_INSERT, 8'h50);
        push_item(OP_INSERT, 8'h60);
        push_item(OP_INSERT, 8'h70);
        push_item(OP_INSERT, 8'h33);   // list now full
        push_item(OP_INSERT, 8'hEE);   // refused, list full
        push_item(OP_FIND,   8'h00);   // hit in the last slot
        push_item(OP_FIND,   8'h5A);   // first of two equal entries
        push_item(OP_DELETE, 8'h33);   // remove the front entry
        push_item(OP_DELETE, 8'h00);   // remove the back entry
        push_item(OP_DELETE, 8'h5A);   // remove from the middle
        push_item(OP_NOP,    8'hC3);   // unused code with entries held
    endtask

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // driver: offers items from the pending queue, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted = list_apply(i_op, i_value);
                expected_results.push_back(predicted);
                n_accepted <= n_accepted + 1;
                case (i_op)
                    OP_INSERT: n_inserts++;
                    OP_FIND:   n_finds++;
                    OP_DELETE: n_deletes++;
                    default:   n_nops++;
                endcase
                if (predicted.status == ST_FULL)
                    n_refused++;
                if (predicted.status == ST_MISS)
                    n_misses++;
                if (list_fill > peak_fill)
                    peak_fill = list_fill;
            end
            // a stalled item stays put, otherwise pick the next or go idle
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_cmd = pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    i_op       <= next_cmd.op;
                    i_value    <= next_cmd.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each accepted result, drives the result stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (expected_results.size() == 0) begin
                if (n_errors < 10)
                    $display("[%0t] unexpected result: pos %0d hit %0d status %0d entries %0d",
                             $realtime, o_position, o_hit, o_status, o_entries);
                n_errors++;
            end else begin
                owed = expected_results.pop_front();
                if (o_position !== owed.position || o_hit !== owed.hit ||
                    o_status !== owed.status || o_entries !== owed.entries) begin
                    if (n_errors < 10) begin
                        $write("[%0t] result %0d mismatch: expected pos %0d hit %0d ",
                               $realtime, n_results, owed.position, owed.hit);
                        $display("status %0d entries %0d, got pos %0d hit %0d status %0d entries %0d",
                                 owed.status, owed.entries, o_position, o_hit,
                                 o_status, o_entries);
                    end
                    n_errors++;
                end
            end
        end

        // one long hold-off while the sender keeps going, then random stalls
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, four idling phases, drain between them
    // ------------------------------------------------------------------
    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0 || i_in_valid)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase 0: no idling, directed items then random with the long stall
        queue_directed_items();
        queue_random_items(PHASE_ITEMS);
        drain();

        // phase 1: sender mostly idle
        send_idle_pct = 77;
        recv_stall_pct = 0;
        queue_random_items(PHASE_ITEMS);
        drain();

        // phase 2: receiver mostly stalling
        send_idle_pct = 0;
        recv_stall_pct = 77;
        queue_random_items(PHASE_ITEMS);
        drain();

        // phase 3: light idling on both sides
        send_idle_pct = 17;
        recv_stall_pct = 17;
        queue_random_items(PHASE_ITEMS);
        drain();

        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d items: %0d inserts, %0d finds, %0d deletes, %0d no-ops; %0d results",
                 n_accepted, n_inserts, n_finds, n_deletes, n_nops, n_results);
        $display("list peaked at %0d entries, %0d inserts refused, %0d misses, %0d mismatches",
                 peak_fill, n_refused, n_misses, n_errors);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("** array_list_insert_find_delete_unit: PASSED **");
        end else begin
            $display("** array_list_insert_find_delete_unit: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT);
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("** array_list_insert_find_delete_unit: FAILED **");
        $finish;
    end

endmodule

### filelist.f
hdl/alifd_pkg.sv
hdl/alifd_cell.sv
hdl/array_list_insert_find_delete_unit.sv
dv/tb_array_list_insert_find_delete_unit.sv
